/* src/utf8_to_ucs2_decoder_unit_assert.svh */
// assertion macros for the utf8 to ucs2 decoder unit
// used by the core and the result queue, no other dependencies
`ifndef UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define UCS2_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define UCS2_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* src/utf8_ucs2_pkg.sv */
// shared types and constants of the utf8 to ucs2 decoder unit
// no dependencies
package utf8_ucs2_pkg;

   localparam logic [15:0] SPACE_UNIT  = 16'h0020;
   localparam logic [7:0]  LIMIT_RESET = 8'd128;
   localparam logic [7:0]  COUNT_MAX   = 8'd255;
   localparam logic [1:0]  PEND_NONE   = 2'd0;
   localparam logic [1:0]  PEND_ONE    = 2'd1;
   localparam logic [1:0]  PEND_TWO    = 2'd2;
   localparam logic [1:0]  PEND_THREE  = 2'd3;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last;
   } entry_type;

   typedef struct packed {
      logic      v0;
      entry_type e0;
      logic      v1;
      entry_type e1;
   } push_type;

endpackage

/* src/utf8_ucs2_core.sv */
// input register, line state and per-byte decode of the utf8 to ucs2 decoder unit
// depends on utf8_ucs2_pkg and utf8_to_ucs2_decoder_unit_assert.svh
`include "utf8_to_ucs2_decoder_unit_assert.svh"

module utf8_ucs2_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_data,
   input  logic                    room,
   output utf8_ucs2_pkg::push_type push
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic [7:0]  limit_ff, limit_in;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  count_ff, count_in;
   logic        draining_ff, draining_in;
   logic        step;
   logic [7:0]  b;
   logic [7:0]  count_inc;
   logic [15:0] acc_shift;
   logic [15:0] unit;
   logic        emit;

   assign step       = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | room;
   assign csr_ready  = 1'b1;
   assign b          = in_byte_ff;
   assign count_inc  = (count_ff == utf8_ucs2_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;
   assign acc_shift  = {acc_ff[9:0], b[5:0]};

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;
   end

   always_comb begin
      pend_in     = pend_ff;
      acc_in      = acc_ff;
      count_in    = count_ff;
      draining_in = draining_ff;
      unit        = 16'd0;
      emit        = 1'b0;
      push        = '0;
      if (step) begin
         if (b == 8'd0) begin
            draining_in = 1'b0;
            pend_in     = utf8_ucs2_pkg::PEND_NONE;
            acc_in      = 16'd0;
            count_in    = 8'd0;
            if (!draining_ff) begin
               push.v0 = 1'b1;
               push.e0 = '{code_unit: 16'd0, last: 1'b1};
            end
         end else if (!draining_ff) begin
            count_in = count_inc;
            if (pend_ff != utf8_ucs2_pkg::PEND_NONE) begin
               acc_in  = acc_shift;
               pend_in = pend_ff - 2'd1;
               if (pend_ff == utf8_ucs2_pkg::PEND_ONE) begin
                  unit = acc_shift;
                  emit = 1'b1;
               end
            end else begin
               unique case (b) inside
                  8'b110?????: begin
                     acc_in  = {11'd0, b[4:0]};
                     pend_in = utf8_ucs2_pkg::PEND_ONE;
                  end
                  8'b1110????: begin
                     acc_in  = {12'd0, b[3:0]};
                     pend_in = utf8_ucs2_pkg::PEND_TWO;
                  end
                  8'b11110???: begin
                     acc_in  = {13'd0, b[2:0]};
                     pend_in = utf8_ucs2_pkg::PEND_THREE;
                  end
                  default: begin
                     unit = {8'd0, b};
                     emit = 1'b1;
                  end
               endcase
            end
            if (emit) begin
               acc_in  = 16'd0;
               push.v0 = 1'b1;
               push.e0 = '{code_unit: (unit < utf8_ucs2_pkg::SPACE_UNIT)
                                      ? utf8_ucs2_pkg::SPACE_UNIT : unit,
                           last: 1'b0};
               if (count_inc >= limit_ff) begin
                  push.v1     = 1'b1;
                  push.e1     = '{code_unit: 16'd0, last: 1'b1};
                  draining_in = 1'b1;
                  pend_in     = utf8_ucs2_pkg::PEND_NONE;
                  count_in    = 8'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         limit_ff    <= utf8_ucs2_pkg::LIMIT_RESET;
         pend_ff     <= utf8_ucs2_pkg::PEND_NONE;
         acc_ff      <= 16'd0;
         count_ff    <= 8'd0;
         draining_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         limit_ff    <= limit_in;
         pend_ff     <= pend_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
         draining_ff <= draining_in;
      end
      in_byte_ff <= in_byte_in;
   end

   `UCS2_ASSERT_NEXT(a_drain_after_term, clock, reset, push.v1, draining_ff, "no drain after terminator")
   `UCS2_ASSERT_NOW(a_second_is_term, clock, reset, push.v1, push.v0 && push.e1.last && !push.e0.last, "bad result pair")
   `UCS2_ASSERT_NOW(a_push_needs_step, clock, reset, push.v0, step, "result without decode step")

endmodule

/* src/utf8_ucs2_queue.sv */
// result queue of the utf8 to ucs2 decoder unit, takes up to two words per cycle while it has room
// depends on utf8_ucs2_pkg and utf8_to_ucs2_decoder_unit_assert.svh
`include "utf8_to_ucs2_decoder_unit_assert.svh"

module utf8_ucs2_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  utf8_ucs2_pkg::push_type  push,
   output logic                     room,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output utf8_ucs2_pkg::entry_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

   utf8_ucs2_pkg::entry_type mem [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in, wr_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign wr_next    = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign room       = (count_ff <= ROOM_MAX);
   assign head       = mem[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      if (push.v1) begin
         wr_in = (wr_next == LAST_PTR) ? '0 : wr_next + PW'(1);
      end else if (push.v0) begin
         wr_in = wr_next;
      end
      rd_in = rd_ff;
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      count_in = count_ff + CW'(push.v0) + CW'(push.v1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push.v0) begin
         mem[wr_ff] <= push.e0;
      end
      if (push.v1) begin
         mem[wr_next] <= push.e1;
      end
   end

   `UCS2_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue overfilled")
   `UCS2_ASSERT_NOW(a_push_with_room, clock, reset, push.v0 || push.v1, room, "push without room")
   `UCS2_ASSERT_NEXT(a_idle_stays_empty, clock, reset, count_ff == '0 && !push.v0, count_ff == '0, "queue filled without push")

endmodule

/* src/utf8_to_ucs2_decoder_unit.sv */
// top level of the utf8 to ucs2 decoder unit: per-byte decode core and result queue
// depends on utf8_ucs2_pkg, utf8_ucs2_core and utf8_ucs2_queue
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata[7:0] data_byte
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[15:0] code_unit, rsp_tlast last
//  csr      in         csr_valid/csr_ready    csr_data[7:0] byte_limit
//
// one byte a cycle while the queue has room: input register, one decode step, then the result queue
// a byte that ends a line on budget gives two words
// req_tready drops only while the queue has no room for two words
// reset clears line state and the queue, byte_limit returns to 128
// csr_ready is always high
module utf8_to_ucs2_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // code_unit
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   utf8_ucs2_pkg::push_type  push;
   utf8_ucs2_pkg::entry_type head;
   logic                     room;

   utf8_ucs2_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .room       (room),
      .push       (push)
   );

   utf8_ucs2_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.code_unit;
   assign rsp_tlast = head.last;

endmodule
